### rtl/ptpdf_pkg.sv
// shared types and constants for the ptp/ip transaction deframer
package ptpdf_pkg;

  localparam logic [31:0] TYPE_RESPONSE   = 32'd7;
  localparam logic [31:0] TYPE_EVENT      = 32'd8;
  localparam logic [31:0] TYPE_DATA_START = 32'd9;
  localparam logic [31:0] TYPE_DATA       = 32'd10;
  localparam logic [31:0] TYPE_DATA_END   = 32'd12;

  localparam logic [31:0] HDR_BYTES = 32'd8;
  localparam logic [31:0] TID_BYTES = 32'd4;
  // last payload index is length minus header minus one
  localparam logic [31:0] LAST_OFS  = 32'd9;
  // header count value that marks the payload phase
  localparam logic [3:0]  HC_PAYLOAD = 4'd8;
  localparam logic [3:0]  HC_LAST_HDR = 4'd7;

  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_START    = 3'd1,
    KIND_RESPONSE = 3'd2,
    KIND_BAD_LEN  = 3'd3,
    KIND_BAD_TYPE = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [15:0] response_code;
    logic [31:0] bad_type;
  } res_t;

  function automatic logic type_known(input logic [31:0] t);
    return (t == TYPE_RESPONSE) || (t == TYPE_EVENT) ||
           (t == TYPE_DATA_START) || (t == TYPE_DATA) ||
           (t == TYPE_DATA_END);
  endfunction

endpackage

### rtl/ptpdf_if.sv
// channel interfaces: received bytes, results and the capture register write
interface ptpdf_in_if import ptpdf_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ptpdf_out_if import ptpdf_pkg::*; ();
  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [7:0]  data_byte;
  logic [15:0] response_code;
  logic [31:0] bad_type;

  modport source (output valid, output kind, output data_byte, output response_code,
                  output bad_type, input ready);
  modport sink   (input valid, input kind, input data_byte, input response_code,
                  input bad_type, output ready);
endinterface

interface ptpdf_cfg_if import ptpdf_pkg::*; ();
  logic valid;
  logic ready;
  logic capture_data;

  modport source (output valid, output capture_data, input ready);
  modport sink   (input valid, input capture_data, output ready);
endinterface

### rtl/ptpip_transaction_deframer.sv
// ptp/ip command-channel transaction deframer top level
//
//   channel   | dir | payload                                       | role
//   in_bus    | in  | rx_byte                                       | received bytes
//   out_bus   | out | kind, data_byte, response_code, bad_type      | results
//   cfg_bus   | in  | capture_data                                  | capture enable write
//
// one byte is taken every cycle; a result appears in the output register the
// cycle after its byte, set by the single parser pass and one result register.
// the input stalls only while the output register is full and not drained.
// rst_n clears framing state, the halt flag and the output valid; capture resets to 1.
// after a bad length or type the block keeps taking bytes but gives no transfer.
module ptpip_transaction_deframer import ptpdf_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  ptpdf_in_if.sink      in_bus,
  ptpdf_out_if.source   out_bus,
  ptpdf_cfg_if.sink     cfg_bus
);

  logic capture_r;
  logic take;
  logic res_valid;
  res_t res;
  logic out_valid_r;
  res_t out_r;

  assign cfg_bus.ready = 1'b1;
  assign in_bus.ready  = !out_valid_r || out_bus.ready;
  assign take          = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capture_r <= 1'b1;
    end else if (cfg_bus.valid) begin
      capture_r <= cfg_bus.capture_data;
    end
  end

  ptpdf_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .rx_byte      (in_bus.rx_byte),
    .capture_data (capture_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_r <= res;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.kind          = out_r.kind;
  assign out_bus.data_byte     = out_r.data_byte;
  assign out_bus.response_code = out_r.response_code;
  assign out_bus.bad_type      = out_r.bad_type;

endmodule

### rtl/ptpdf_parser.sv
// packet framing state and per-byte result decode
module ptpdf_parser import ptpdf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] rx_byte,
  input  logic       capture_data,
  output logic       res_valid,
  output res_t       res
);

  logic [3:0]  hc_r, hc_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] type_r, type_nxt;
  logic [31:0] idx_r, idx_nxt;
  logic [7:0]  code_lo_r, code_lo_nxt;
  logic [7:0]  code_hi_r, code_hi_nxt;
  logic        halted_r, halted_nxt;

  logic [31:0] full_type;
  logic        last;

  assign full_type = {rx_byte, type_r[23:0]};
  assign last      = (idx_r == (len_r - LAST_OFS));

  always_comb begin
    hc_nxt      = hc_r;
    len_nxt     = len_r;
    type_nxt    = type_r;
    idx_nxt     = idx_r;
    code_lo_nxt = code_lo_r;
    code_hi_nxt = code_hi_r;
    halted_nxt  = halted_r;
    res_valid   = 1'b0;
    res         = '0;
    if (take && !halted_r) begin
      if (hc_r != HC_PAYLOAD) begin
        // header fields start from zero, so each byte lands in its lane
        if (!hc_r[2]) begin
          len_nxt[{hc_r[1:0], 3'b000} +: 8] = rx_byte;
        end else begin
          type_nxt[{hc_r[1:0], 3'b000} +: 8] = rx_byte;
        end
        hc_nxt = hc_r + 4'd1;
        if (hc_r == HC_LAST_HDR) begin
          if (len_r < HDR_BYTES) begin
            halted_nxt = 1'b1;
            res_valid  = 1'b1;
            res.kind   = KIND_BAD_LEN;
          end else if (!type_known(full_type)) begin
            halted_nxt   = 1'b1;
            res_valid    = 1'b1;
            res.kind     = KIND_BAD_TYPE;
            res.bad_type = full_type;
          end else begin
            idx_nxt     = '0;
            code_lo_nxt = '0;
            code_hi_nxt = '0;
            if (len_r == HDR_BYTES) begin
              // empty payload: packet ends with its header
              hc_nxt   = '0;
              len_nxt  = '0;
              type_nxt = '0;
              if (full_type == TYPE_DATA_START) begin
                res_valid = 1'b1;
                res.kind  = KIND_START;
              end else if (full_type == TYPE_RESPONSE) begin
                res_valid = 1'b1;
                res.kind  = KIND_RESPONSE;
              end
            end
          end
        end
      end else begin
        if (type_r == TYPE_RESPONSE) begin
          if (idx_r == 32'd0) begin
            code_lo_nxt = rx_byte;
          end else if (idx_r == 32'd1) begin
            code_hi_nxt = rx_byte;
          end
        end else if (type_r == TYPE_DATA || type_r == TYPE_DATA_END) begin
          // transaction id bytes are skipped
          if (idx_r >= TID_BYTES && capture_data) begin
            res_valid     = 1'b1;
            res.kind      = KIND_DATA;
            res.data_byte = rx_byte;
          end
        end
        idx_nxt = idx_r + 32'd1;
        if (last) begin
          hc_nxt   = '0;
          idx_nxt  = '0;
          len_nxt  = '0;
          type_nxt = '0;
          if (type_r == TYPE_DATA_START) begin
            res_valid = 1'b1;
            res.kind  = KIND_START;
          end else if (type_r == TYPE_RESPONSE) begin
            res_valid         = 1'b1;
            res.kind          = KIND_RESPONSE;
            res.response_code = {code_hi_nxt, code_lo_nxt};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r      <= '0;
      len_r     <= '0;
      type_r    <= '0;
      idx_r     <= '0;
      code_lo_r <= '0;
      code_hi_r <= '0;
      halted_r  <= 1'b0;
    end else begin
      hc_r      <= hc_nxt;
      len_r     <= len_nxt;
      type_r    <= type_nxt;
      idx_r     <= idx_nxt;
      code_lo_r <= code_lo_nxt;
      code_hi_r <= code_hi_nxt;
      halted_r  <= halted_nxt;
    end
  end

`ifndef SYNTHESIS
  a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt flag cleared without reset");

  a_hc_range: assert property (@(posedge clk) disable iff (!rst_n)
    hc_r <= HC_PAYLOAD)
    else $error("header count out of range");

  a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && (res.kind == KIND_BAD_LEN || res.kind == KIND_BAD_TYPE) |=> halted_r)
    else $error("framing error did not halt");

  a_quiet_when_halted: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> !res_valid)
    else $error("result produced while halted");
`endif

endmodule
